FILE: design/bessel_first_kind_series_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Bessel series unit
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BESSEL_FIRST_KIND_SERIES_UNIT_ASSERT_SVH
`define BESSEL_FIRST_KIND_SERIES_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BFKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bfks_pkg.sv
// ----------------------------------------------------------------------------
// bfks_pkg
// Widths, constants, state codes and the first-term table of the Bessel unit.
// ----------------------------------------------------------------------------
package bfks_pkg;

  localparam int MAX_TERMS     = 32;
  localparam int ACC_FRAC_BITS = 40;

  // Field widths.
  localparam int ORDER_W    = 4;
  localparam int ORDER_MAX  = 15;
  localparam int ARG_W      = 16;
  localparam int TOL_W      = 32;
  localparam int OUT_W      = 32;
  localparam int TERMS_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Term and accumulator magnitude width; all magnitudes clamp to all ones.
  localparam int TMAG_W = ((ACC_FRAC_BITS + 16) > 62) ? 62 : (ACC_FRAC_BITS + 16);
  localparam logic [TMAG_W-1:0] ACC_LIMIT = '1;

  // Series index and term counters.
  localparam int K_W   = $clog2(MAX_TERMS);
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  // Divisor k*(n+k), largest at the last term for the largest order.
  localparam int D_MAX = (MAX_TERMS - 1) * (ORDER_MAX + MAX_TERMS - 1);
  localparam int D_W   = $clog2(D_MAX + 1);

  // Shared multiplier: the wide operand is split into two halves.
  localparam int HALF_W = (TMAG_W + 1) / 2;
  localparam int MB_W   = 32;
  localparam int PP_W   = HALF_W + MB_W;
  localparam int PROD_W = 2 * HALF_W + MB_W;

  // Binary point shifts of the three products.
  localparam int Q_SHIFT   = 26;
  localparam int TOL_SHIFT = 32;
  localparam int POW_SHIFT = 13;

  // Radix-16 divider.
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = (TMAG_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DVD_W     = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Output scaling to Q1.30.
  localparam int FRAC_DOWN = (ACC_FRAC_BITS > 30) ? (ACC_FRAC_BITS - 30) : 0;
  localparam int FRAC_UP   = (ACC_FRAC_BITS < 30) ? (30 - ACC_FRAC_BITS) : 0;
  localparam logic [63:0] RND_HALF = (FRAC_DOWN > 0) ? (64'd1 << (FRAC_DOWN - 1)) : 64'd0;
  localparam logic [63:0] OUT_ONE  = 64'd1 << 30;

  // First term 1/n!, rounded to nearest.
  localparam logic [63:0] ACC_ONE = 64'd1 << ACC_FRAC_BITS;
  localparam logic [TMAG_W-1:0] FIRST_TERM [16] = '{
    TMAG_W'((ACC_ONE + 64'd1 / 2) / 64'd1),
    TMAG_W'((ACC_ONE + 64'd1 / 2) / 64'd1),
    TMAG_W'((ACC_ONE + 64'd2 / 2) / 64'd2),
    TMAG_W'((ACC_ONE + 64'd6 / 2) / 64'd6),
    TMAG_W'((ACC_ONE + 64'd24 / 2) / 64'd24),
    TMAG_W'((ACC_ONE + 64'd120 / 2) / 64'd120),
    TMAG_W'((ACC_ONE + 64'd720 / 2) / 64'd720),
    TMAG_W'((ACC_ONE + 64'd5040 / 2) / 64'd5040),
    TMAG_W'((ACC_ONE + 64'd40320 / 2) / 64'd40320),
    TMAG_W'((ACC_ONE + 64'd362880 / 2) / 64'd362880),
    TMAG_W'((ACC_ONE + 64'd3628800 / 2) / 64'd3628800),
    TMAG_W'((ACC_ONE + 64'd39916800 / 2) / 64'd39916800),
    TMAG_W'((ACC_ONE + 64'd479001600 / 2) / 64'd479001600),
    TMAG_W'((ACC_ONE + 64'd6227020800 / 2) / 64'd6227020800),
    TMAG_W'((ACC_ONE + 64'd87178291200 / 2) / 64'd87178291200),
    TMAG_W'((ACC_ONE + 64'd1307674368000 / 2) / 64'd1307674368000)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER     = 1'b0,
    CFG_TOLERANCE = 1'b1
  } bfks_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_INIT,
    S_TLO,
    S_THI,
    S_TSAT,
    S_DIV,
    S_BLO,
    S_BHI,
    S_CHK,
    S_PSET,
    S_PLO,
    S_PHI,
    S_PSAT,
    S_FIN
  } bfks_state_e;

endpackage

FILE: design/bessel_first_kind_series_unit.sv
// ----------------------------------------------------------------------------
// bessel_first_kind_series_unit
// A new request is taken only after the previous result has moved into the
// output register; a result waits there and the input reopens meanwhile.
// Each further term runs two multiplier passes, a divide (start, 14 radix-16
// steps, result), two stop-test passes and a check.
// Reset (asynchronous, active low): order = 0, tolerance = 4295, idle.
// ----------------------------------------------------------------------------
module bessel_first_kind_series_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bfks_pkg::ARG_W-1:0]             arg_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bfks_pkg::OUT_W-1:0]      bessel_value_o,
  output logic                                   converged_o,
  output logic [bfks_pkg::TERMS_W-1:0]           terms_used_o,
  input  logic                                   cfg_we_i,
  input  logic [bfks_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bfks_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import bfks_pkg::*;

  localparam int RND_W = TMAG_W + FRAC_UP + 1;

  bfks_state_e state_q, state_d;

  // Configuration registers.
  logic [ORDER_W-1:0] order_q, order_d;
  logic [TOL_W-1:0]   tol_q, tol_d;

  // Working registers of the series evaluation.
  logic [ARG_W-1:0]   x_q, x_d;
  logic [MB_W-1:0]    q_q, q_d;
  logic [TMAG_W-1:0]  tmag_q, tmag_d;
  logic signed [TMAG_W:0] sum_q, sum_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [D_W-1:0]     d_q, d_d;
  logic [CNT_W-1:0]   terms_q, terms_d;
  logic               conv_q, conv_d;
  logic               neg_q, neg_d;
  logic [ORDER_W-1:0] pcnt_q, pcnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   bess_q, bess_d;
  logic               oconv_q, oconv_d;
  logic [TERMS_W-1:0] oterms_q, oterms_d;

  // Shared multiplier operands.
  logic [2*HALF_W-1:0] a_wide;
  logic [HALF_W-1:0]   a_part;
  logic [MB_W-1:0]     b_op;
  logic [PP_W-1:0]     pp;
  logic                mul_hi;

  // Divider hookup.
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic               div_done;
  logic [DVD_W-1:0]   div_quot;

  // Derived values.
  logic                   accept;
  logic                   load_out;
  logic [TMAG_W:0]        sum_neg;
  logic [TMAG_W-1:0]      sum_abs;
  logic [TMAG_W-1:0]      tq_sat;
  logic [TMAG_W-1:0]      pow_sat;
  logic [2*HALF_W-1:0]    bound;
  logic                   stop_hit;
  logic                   last_term;
  logic [TMAG_W-1:0]      new_term;
  logic signed [TMAG_W+1:0] sum_ext, term_ext, sum_add, lim_pos, lim_neg;
  logic [RND_W-1:0]       rnd_sum, rnd_scaled;
  logic [30:0]            out_mag;
  logic [OUT_W-1:0]       out_word;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // The result leaves the datapath when the output register is empty or
  // is being drained in the same cycle.
  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Magnitude of the running sum; it never exceeds the clamp limit.
  assign sum_neg = -sum_q;
  assign sum_abs = sum_q[TMAG_W] ? sum_neg[TMAG_W-1:0] : sum_q[TMAG_W-1:0];

  // Term product t*q/2^26, clamped to the accumulator limit before dividing.
  assign tq_sat = (|prod_q[PROD_W-1:TMAG_W+Q_SHIFT]) ? ACC_LIMIT :
                  prod_q[TMAG_W+Q_SHIFT-1:Q_SHIFT];

  // Power step |v|*x/2^13, clamped the same way.
  assign pow_sat = (|prod_q[PROD_W-1:TMAG_W+POW_SHIFT]) ? ACC_LIMIT :
                   prod_q[TMAG_W+POW_SHIFT-1:POW_SHIFT];

  // Relative stop test without a divide: |t| <= |sum|*tol/2^32.
  assign bound     = prod_q[PROD_W-1:TOL_SHIFT];
  assign stop_hit  = ((2*HALF_W)'(tmag_q) <= bound);
  assign last_term = (k_q == K_W'(MAX_TERMS - 1));

  // Accumulate the freshly divided term; odd terms are subtracted.
  assign new_term = div_quot[TMAG_W-1:0];
  assign sum_ext  = {sum_q[TMAG_W], sum_q};
  assign term_ext = $signed({2'b00, new_term});
  assign lim_pos  = $signed({2'b00, ACC_LIMIT});
  assign lim_neg  = -lim_pos;
  assign sum_add  = k_q[0] ? (sum_ext - term_ext) : (sum_ext + term_ext);

  // Round the final magnitude to Q.30, half away from zero, and clamp at one.
  assign rnd_sum    = RND_W'(tmag_q) + RND_W'(RND_HALF);
  assign rnd_scaled = (rnd_sum >> FRAC_DOWN) << FRAC_UP;
  assign out_mag    = (rnd_scaled > RND_W'(OUT_ONE)) ? OUT_ONE[30:0] : rnd_scaled[30:0];
  assign out_word   = neg_q ? (OUT_W'(0) - {1'b0, out_mag}) : {1'b0, out_mag};

  // The one multiplier: a half of the wide operand times a 32-bit operand.
  // A low pass loads the product register; a high pass adds its product in
  // one half-width up.
  always_comb begin
    a_wide = '0;
    b_op   = '0;
    mul_hi = 1'b0;
    case (state_q)
      S_SQ: begin
        a_wide = (2*HALF_W)'(x_q);
        b_op   = MB_W'(x_q);
      end
      S_TLO, S_THI: begin
        a_wide = (2*HALF_W)'(tmag_q);
        b_op   = q_q;
        mul_hi = (state_q == S_THI);
      end
      S_BLO, S_BHI: begin
        a_wide = (2*HALF_W)'(sum_abs);
        b_op   = tol_q;
        mul_hi = (state_q == S_BHI);
      end
      S_PLO, S_PHI: begin
        a_wide = (2*HALF_W)'(tmag_q);
        b_op   = MB_W'(x_q);
        mul_hi = (state_q == S_PHI);
      end
      default: begin
        a_wide = '0;
      end
    endcase
  end

  assign a_part = mul_hi ? a_wide[2*HALF_W-1:HALF_W] : a_wide[HALF_W-1:0];
  assign pp     = PP_W'(a_part) * PP_W'(b_op);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SQ;
      end
      S_SQ:   state_d = S_INIT;
      S_INIT: state_d = S_TLO;
      S_TLO:  state_d = S_THI;
      S_THI:  state_d = S_TSAT;
      S_TSAT: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_BLO;
      end
      S_BLO:  state_d = S_BHI;
      S_BHI:  state_d = S_CHK;
      S_CHK: begin
        state_d = (stop_hit || last_term) ? S_PSET : S_TLO;
      end
      S_PSET: begin
        state_d = (order_q == '0) ? S_FIN : S_PLO;
      end
      S_PLO:  state_d = S_PHI;
      S_PHI:  state_d = S_PSAT;
      S_PSAT: begin
        state_d = ((pcnt_q + ORDER_W'(1)) == order_q) ? S_FIN : S_PLO;
      end
      S_FIN: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath updates and sequencer outputs.
  always_comb begin
    order_d      = order_q;
    tol_d        = tol_q;
    x_d          = x_q;
    q_d          = q_q;
    tmag_d       = tmag_q;
    sum_d        = sum_q;
    k_d          = k_q;
    d_d          = d_q;
    terms_d      = terms_q;
    conv_d       = conv_q;
    neg_d        = neg_q;
    pcnt_d       = pcnt_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    div_dividend = DVD_W'(tq_sat);

    // Register writes must arrive only while no request is in work; the block does not enforce this.
    if (cfg_we_i) begin
      case (bfks_cfg_e'(cfg_index_i))
        CFG_ORDER:     order_d = cfg_wdata_i[ORDER_W-1:0];
        CFG_TOLERANCE: tol_d   = cfg_wdata_i[TOL_W-1:0];
        default:       order_d = order_q;
      endcase
    end

    if (mul_hi) begin
      prod_d = prod_q + (PROD_W'(pp) << HALF_W);
    end

    case (state_q)
      S_IDLE: begin
        if (accept) x_d = arg_value_i;
      end
      S_SQ: begin
        // x*x is Q.24, which read as Q.26 is x*x/4.
        prod_d = PROD_W'(pp);
      end
      S_INIT: begin
        q_d     = prod_q[MB_W-1:0];
        tmag_d  = FIRST_TERM[order_q];
        sum_d   = $signed({1'b0, FIRST_TERM[order_q]});
        k_d     = K_W'(1);
        d_d     = D_W'(order_q) + D_W'(1);
        terms_d = CNT_W'(1);
        conv_d  = 1'b0;
      end
      S_TLO, S_BLO, S_PLO: begin
        prod_d = PROD_W'(pp);
      end
      S_TSAT: begin
        div_start = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          tmag_d  = new_term;
          terms_d = terms_q + CNT_W'(1);
          if (sum_add > lim_pos) begin
            sum_d = lim_pos[TMAG_W:0];
          end else if (sum_add < lim_neg) begin
            sum_d = lim_neg[TMAG_W:0];
          end else begin
            sum_d = sum_add[TMAG_W:0];
          end
        end
      end
      S_CHK: begin
        conv_d = stop_hit;
        if (!stop_hit && !last_term) begin
          // k*(n+k) grows to (k+1)*(n+k+1) by adding n + 2k + 1.
          k_d = k_q + K_W'(1);
          d_d = d_q + D_W'(order_q) + D_W'({k_q, 1'b1});
        end
      end
      S_PSET: begin
        // From here on the term register carries the magnitude being scaled.
        tmag_d = sum_abs;
        neg_d  = sum_q[TMAG_W];
        pcnt_d = '0;
      end
      S_PSAT: begin
        tmag_d = pow_sat;
        pcnt_d = pcnt_q + ORDER_W'(1);
      end
      default: begin
        prod_d = prod_d;
      end
    endcase
  end

  // Output register: a result waits here until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    bess_d      = bess_q;
    oconv_d     = oconv_q;
    oterms_d    = oterms_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      bess_d      = out_word;
      oconv_d     = conv_q;
      oterms_d    = TERMS_W'(terms_q);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  bfks_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= '0;
      tol_q       <= TOL_W'(4295);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      order_q     <= order_d;
      tol_q       <= tol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    q_q      <= q_d;
    tmag_q   <= tmag_d;
    sum_q    <= sum_d;
    k_q      <= k_d;
    d_q      <= d_d;
    terms_q  <= terms_d;
    conv_q   <= conv_d;
    neg_q    <= neg_d;
    pcnt_q   <= pcnt_d;
    prod_q   <= prod_d;
    bess_q   <= bess_d;
    oconv_q  <= oconv_d;
    oterms_q <= oterms_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bessel_value_o = $signed(bess_q);
  assign converged_o    = oconv_q;
  assign terms_used_o   = oterms_q;

endmodule

FILE: design/bfks_div.sv
// ----------------------------------------------------------------------------
// bfks_div
// Radix-16 restoring divider: four quotient bits per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module bfks_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfks_pkg::DVD_W-1:0] dividend_i,
  input  logic [bfks_pkg::D_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic [bfks_pkg::DVD_W-1:0] quotient_o
);
  import bfks_pkg::*;

  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [D_W-1:0]       rem_q, rem_d;
  logic [D_W-1:0]       dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [D_W:0]         trial;
  logic [D_W-1:0]       rem_w;
  logic [DIV_DIGIT-1:0] qdig;

  // Four dependent compare-subtract steps on a remainder below the divisor.
  always_comb begin
    rem_w = rem_q;
    trial = '0;
    qdig  = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial = {rem_w, dvd_q[DVD_W-1-i]};
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
        qdig[DIV_DIGIT-1-i] = 1'b1;
      end
      rem_w = trial[D_W-1:0];
    end
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-DIV_DIGIT-1:0], qdig};
      rem_d  = rem_w;
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

FILE: design/bfks_checker.sv
// ----------------------------------------------------------------------------
// bfks_checker
// Port-level checks of the Bessel series unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "bessel_first_kind_series_unit_assert.svh"

module bfks_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [bfks_pkg::OUT_W-1:0] bessel_value_o,
  input logic                              converged_o,
  input logic [bfks_pkg::TERMS_W-1:0]      terms_used_o
);
  import bfks_pkg::*;

  // A stalled result stays put.
  `BFKS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(bessel_value_o) && $stable(converged_o) && $stable(terms_used_o), "stalled result changed")

  // One request is in work at a time: taking one closes the input.
  `BFKS_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input open right after a request")

  // The result never leaves the closed interval from minus one to one.
  `BFKS_ASSERT_IMP(a_out_range, out_valid_o, (bessel_value_o <= 32'sd1073741824) && (bessel_value_o >= -32'sd1073741824), "result outside Q1.30 range")

  // Running out of terms always reports the full term count.
  `BFKS_ASSERT_IMP(a_limit_count, out_valid_o && !converged_o, terms_used_o == TERMS_W'(MAX_TERMS), "unconverged result with short term count")

endmodule

bind bessel_first_kind_series_unit bfks_checker u_bfks_checker (.*);
